// ===== hdl/bs_pkg.sv =====
package bs_pkg;

  localparam int ITER_BITS = 12;
  localparam int FRAC_BITS = 28;
  localparam int PIX_W     = 12;
  localparam int SCALE_W   = 31;
  localparam int WORD_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DIFF_W    = PIX_W + 1;
  localparam int OP_W      = WORD_W + 1;
  localparam int PROD_W    = 64;
  localparam int SUM_W     = PROD_W + 2;

  localparam logic [ITER_BITS-1:0] MAX_ITER_RST = ITER_BITS'(255);
  localparam logic [SCALE_W-1:0]   SCALE_RST    = SCALE_W'(1491308);

  // |z|^2 is held at 2*FRAC_BITS fraction bits; 4 must still fit in the word
  localparam bit CAN_ESCAPE = (2 * FRAC_BITS + 2) < PROD_W;
  localparam logic [PROD_W-1:0] NORM_LIMIT =
    CAN_ESCAPE ? (PROD_W'(1) << (2 * FRAC_BITS + 2)) : '0;

  localparam logic signed [SUM_W-1:0] WORD_MAX = SUM_W'(64'sh0000_0000_7fff_ffff);
  localparam logic signed [SUM_W-1:0] WORD_MIN = SUM_W'(-64'sh0000_0000_8000_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ITER  = 3'd0,
    CFG_CENTER_X  = 3'd1,
    CFG_CENTER_Y  = 3'd2,
    CFG_SCALE_X   = 3'd3,
    CFG_SCALE_Y   = 3'd4,
    CFG_OFFSET_RE = 3'd5,
    CFG_OFFSET_IM = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CROSS,
    ST_UPDATE
  } bs_state_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic signed [WORD_W-1:0] res;
    if (v > WORD_MAX) begin
      res = WORD_MAX[WORD_W-1:0];
    end else if (v < WORD_MIN) begin
      res = WORD_MIN[WORD_W-1:0];
    end else begin
      res = v[WORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/bs_mul.sv =====
module bs_mul
  import bs_pkg::*;
(
  input  logic                     clk,
  input  logic signed [OP_W-1:0]   op_a,
  input  logic signed [OP_W-1:0]   op_b,
  output logic signed [PROD_W-1:0] prod_r
);

  logic signed [2*OP_W-1:0] full;

  assign full = op_a * op_b;

  // every operand pair used here has a product that fits in PROD_W bits
  always_ff @(posedge clk) begin
    prod_r <= full[PROD_W-1:0];
  end

endmodule

// ===== hdl/burning_ship_escape_time.sv =====
// Burning Ship escape-time evaluator.
// Input channel: pulse start with in_pixel_x/in_pixel_y while busy is low; the item
// is taken at that edge and busy stays high until its result is issued.
// Result channel: out_valid is high for exactly one cycle with out_iteration_count,
// out_x and out_y. The receiver cannot stall, so the result is simply presented.
// Configuration: cfg_we with cfg_index/cfg_data writes one register at the edge;
// write only while busy is low.
// One signed 33x33 multiplier with a registered product is shared by all steps:
// two steps map the pixel to c, then each escape iteration takes four steps
// (re^2, im^2, re*im, update). The result strobe is registered from the final
// re*im step, which tests for escape and the bound; busy falls in the same cycle,
// so the next item may be started then. The default iteration bound is 255.
// Reset (rst_n low, synchronous) returns to idle, drops any item in flight and
// restores the register defaults.
module burning_ship_escape_time
  import bs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [PIX_W-1:0]     in_pixel_x,
  input  logic [PIX_W-1:0]     in_pixel_y,
  output logic                 out_valid,
  output logic [ITER_BITS-1:0] out_iteration_count,
  output logic [PIX_W-1:0]     out_x,
  output logic [PIX_W-1:0]     out_y,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  bs_state_t state_r, state_nxt;

  logic [ITER_BITS-1:0]     max_iter_r;
  logic [PIX_W-1:0]         center_x_r, center_y_r;
  logic [SCALE_W-1:0]       scale_x_r, scale_y_r;
  logic signed [WORD_W-1:0] offset_re_r, offset_im_r;

  logic [PIX_W-1:0]         px_r, py_r;
  logic signed [WORD_W-1:0] c_re_r, c_im_r, re_r, im_r;
  logic signed [PROD_W-1:0] sq_re_r, sq_im_r;
  logic [ITER_BITS-1:0]     cnt_r;
  logic                     out_valid_r;
  logic [ITER_BITS-1:0]     out_count_r;
  logic [PIX_W-1:0]         out_x_r, out_y_r;

  logic signed [OP_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0] prod_r;

  logic signed [DIFF_W-1:0] diff_x, diff_y;
  logic [PROD_W-1:0]        norm;
  logic                     escape, at_bound, done;
  logic [ITER_BITS-1:0]     done_count;
  logic signed [PROD_W-1:0] sq_diff, sq_shift;
  logic [PROD_W-1:0]        cross_mag, cross_shift;
  logic signed [WORD_W-1:0] c_re_nxt, c_im_nxt, re_nxt, im_nxt;
  logic                     accept;

  bs_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign diff_x = $signed({1'b0, px_r}) - $signed({1'b0, center_x_r});
  assign diff_y = $signed({1'b0, py_r}) - $signed({1'b0, center_y_r});

  // mapping: the product of the previous cycle plus the offset
  assign c_re_nxt = sat_word(SUM_W'(prod_r) + SUM_W'(offset_re_r));
  assign c_im_nxt = sat_word(SUM_W'(prod_r) + SUM_W'(offset_im_r));

  // in CROSS the multiplier output holds im^2 of the current z
  assign norm     = $unsigned(sq_re_r) + $unsigned(prod_r);
  assign escape   = CAN_ESCAPE && (norm > NORM_LIMIT);
  assign at_bound = (cnt_r == max_iter_r);

  // in UPDATE the multiplier output holds re*im
  assign sq_diff     = sq_re_r - sq_im_r;
  assign sq_shift    = sq_diff >>> FRAC_BITS;
  assign cross_mag   = prod_r[PROD_W-1] ? (PROD_W'(0) - $unsigned(prod_r)) : $unsigned(prod_r);
  assign cross_shift = cross_mag >> (FRAC_BITS - 1);
  assign re_nxt      = sat_word(SUM_W'(sq_shift) + SUM_W'(c_re_r));
  assign im_nxt      = sat_word($signed({2'b00, cross_shift}) + SUM_W'(c_im_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_MAP_RE;
      ST_MAP_RE: state_nxt = ST_MAP_IM;
      ST_MAP_IM: state_nxt = ST_SQ_RE;
      ST_SQ_RE:  state_nxt = ST_SQ_IM;
      ST_SQ_IM:  state_nxt = ST_CROSS;
      ST_CROSS:  state_nxt = (escape || at_bound) ? ST_IDLE : ST_UPDATE;
      ST_UPDATE: state_nxt = ST_SQ_RE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op_a       = '0;
    op_b       = '0;
    done       = 1'b0;
    // escape of z_k means k-1 iterations completed without escaping
    done_count = escape ? (cnt_r - ITER_BITS'(1)) : cnt_r;
    unique case (state_r)
      ST_MAP_RE: begin
        op_a = OP_W'(diff_x);
        op_b = $signed({2'b00, scale_x_r});
      end
      ST_MAP_IM: begin
        op_a = OP_W'(diff_y);
        op_b = $signed({2'b00, scale_y_r});
      end
      ST_SQ_RE: begin
        op_a = OP_W'(re_r);
        op_b = OP_W'(re_r);
      end
      ST_SQ_IM: begin
        op_a = OP_W'(im_r);
        op_b = OP_W'(im_r);
      end
      ST_CROSS: begin
        op_a = OP_W'(re_r);
        op_b = OP_W'(im_r);
        done = escape || at_bound;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      max_iter_r  <= MAX_ITER_RST;
      center_x_r  <= '0;
      center_y_r  <= '0;
      scale_x_r   <= SCALE_RST;
      scale_y_r   <= SCALE_RST;
      offset_re_r <= '0;
      offset_im_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= done;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_MAX_ITER:  max_iter_r  <= cfg_data[ITER_BITS-1:0];
          CFG_CENTER_X:  center_x_r  <= cfg_data[PIX_W-1:0];
          CFG_CENTER_Y:  center_y_r  <= cfg_data[PIX_W-1:0];
          CFG_SCALE_X:   scale_x_r   <= cfg_data[SCALE_W-1:0];
          CFG_SCALE_Y:   scale_y_r   <= cfg_data[SCALE_W-1:0];
          CFG_OFFSET_RE: offset_re_r <= $signed(cfg_data[WORD_W-1:0]);
          CFG_OFFSET_IM: offset_im_r <= $signed(cfg_data[WORD_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r  <= in_pixel_x;
      py_r  <= in_pixel_y;
      re_r  <= '0;
      im_r  <= '0;
      cnt_r <= '0;
    end
    case (state_r)
      ST_MAP_IM: c_re_r  <= c_re_nxt;
      ST_SQ_RE:  if (cnt_r == '0) c_im_r <= c_im_nxt;
      ST_SQ_IM:  sq_re_r <= prod_r;
      ST_CROSS:  sq_im_r <= prod_r;
      ST_UPDATE: begin
        re_r  <= re_nxt;
        im_r  <= im_nxt;
        cnt_r <= cnt_r + ITER_BITS'(1);
      end
      default: ;
    endcase
    if (done) begin
      out_count_r <= done_count;
      out_x_r     <= px_r;
      out_y_r     <= py_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_x               = out_x_r;
  assign out_y               = out_y_r;

endmodule

// ===== hdl/bs_chk.sv =====
module bs_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // an accepted item holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // a result is issued exactly when the item in flight finishes
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result not preceded by work on an item");

  // no item is short enough to give two results in successive cycles
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

endmodule

bind burning_ship_escape_time bs_chk u_bs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// ===== test/burning_ship_escape_time_tb.sv =====
module burning_ship_escape_time_tb;
  import bs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam longint WORD_HI = 64'sd2147483647;
  localparam longint WORD_LO = -64'sd2147483648;
  localparam bit ESC_REACHABLE = (2 * FRAC_BITS + 2) < 64;
  localparam logic [63:0] ESC_NORM = 64'd1 << ((2 * FRAC_BITS + 2) % 64);
  localparam int unsigned RANDOM_PIXELS = 850;
  // three units of the fixed-point format, spread over a window of pixels
  localparam int unsigned WINDOW_SPAN = 32'd805306368;

  typedef struct {
    logic [ITER_BITS-1:0]     bound;
    logic [PIX_W-1:0]         cx;
    logic [PIX_W-1:0]         cy;
    logic [SCALE_W-1:0]       sx;
    logic [SCALE_W-1:0]       sy;
    logic signed [WORD_W-1:0] ore;
    logic signed [WORD_W-1:0] oim;
  } view_t;

  typedef struct {
    logic [ITER_BITS-1:0] cnt;
    logic [PIX_W-1:0]     x;
    logic [PIX_W-1:0]     y;
    bit                   held;
  } pixel_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [PIX_W-1:0]     in_pixel_x = '0;
  logic [PIX_W-1:0]     in_pixel_y = '0;
  logic                 out_valid;
  logic [ITER_BITS-1:0] out_iteration_count;
  logic [PIX_W-1:0]     out_x;
  logic [PIX_W-1:0]     out_y;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int unsigned pixels_sent = 0;
  int unsigned views_loaded = 0;

  function automatic longint clip_word(input longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  // pixel to plane coordinate: exact product, saturate after the offset
  function automatic longint plane_coord(input logic [PIX_W-1:0] pix,
                                         input logic [PIX_W-1:0] cen,
                                         input logic [SCALE_W-1:0] step,
                                         input logic signed [WORD_W-1:0] shift);
    longint d;
    d = longint'(pix) - longint'(cen);
    return clip_word(d * longint'(step) + longint'(shift));
  endfunction

  class escape_ledger;
    view_t         regs;
    pixel_result_t due[$];
    int unsigned   faults;
    int unsigned   checked;
    int unsigned   held_count;

    function new();
      regs.bound = MAX_ITER_RST;
      regs.cx    = '0;
      regs.cy    = '0;
      regs.sx    = SCALE_RST;
      regs.sy    = SCALE_RST;
      regs.ore   = '0;
      regs.oim   = '0;
      faults     = 0;
      checked    = 0;
      held_count = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
      case (idx)
        CFG_MAX_ITER:  regs.bound = v[ITER_BITS-1:0];
        CFG_CENTER_X:  regs.cx = v[PIX_W-1:0];
        CFG_CENTER_Y:  regs.cy = v[PIX_W-1:0];
        CFG_SCALE_X:   regs.sx = v[SCALE_W-1:0];
        CFG_SCALE_Y:   regs.sy = v[SCALE_W-1:0];
        CFG_OFFSET_RE: regs.ore = v[WORD_W-1:0];
        CFG_OFFSET_IM: regs.oim = v[WORD_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [ITER_BITS-1:0] escape_count(input logic [PIX_W-1:0] px,
                                                input logic [PIX_W-1:0] py);
      longint      c_re, c_im, re, im, sq_diff, cross_v, mag, nre, nim;
      logic [63:0] norm;
      int unsigned n;
      c_re = plane_coord(px, regs.cx, regs.sx, regs.ore);
      c_im = plane_coord(py, regs.cy, regs.sy, regs.oim);
      re = 0;
      im = 0;
      n = 0;
      while (n < regs.bound) begin
        sq_diff = re * re - im * im;
        cross_v = re * im;
        mag = (cross_v < 0) ? -cross_v : cross_v;
        nre = clip_word((sq_diff >>> FRAC_BITS) + c_re);
        nim = clip_word((mag >>> (FRAC_BITS - 1)) + c_im);
        norm = $unsigned(nre * nre) + $unsigned(nim * nim);
        re = nre;
        im = nim;
        if (ESC_REACHABLE && norm > ESC_NORM) break;
        n++;
      end
      return n[ITER_BITS-1:0];
    endfunction

    function void note_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
      pixel_result_t r;
      r.cnt  = escape_count(px, py);
      r.x    = px;
      r.y    = py;
      r.held = (r.cnt == regs.bound);
      due.push_back(r);
    endfunction

    function void match_result(input logic [ITER_BITS-1:0] cnt,
                               input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
      pixel_result_t want;
      if (due.size() == 0) begin
        faults++;
        $display("%0t: unexpected result, count %0d x %0d y %0d", $time, cnt, x, y);
        return;
      end
      want = due.pop_front();
      checked++;
      if (want.held) held_count++;
      if (cnt !== want.cnt) begin
        faults++;
        $display("%0t: iteration_count at (%0d,%0d): expected %0d, got %0d",
                 $time, want.x, want.y, want.cnt, cnt);
      end
      if (x !== want.x) begin
        faults++;
        $display("%0t: out_x: expected %0d, got %0d", $time, want.x, x);
      end
      if (y !== want.y) begin
        faults++;
        $display("%0t: out_y: expected %0d, got %0d", $time, want.y, y);
      end
    endfunction
  endclass

  escape_ledger ledger = new();

  burning_ship_escape_time dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .out_valid           (out_valid),
    .out_iteration_count (out_iteration_count),
    .out_x               (out_x),
    .out_y               (out_y),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) ledger.match_result(out_iteration_count, out_x, out_y);
  end

  // hold start high until the block takes the item; call at a rising edge
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
    start <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    do @(posedge clk); while (busy);
    ledger.note_pixel(px, py);
    pixels_sent++;
  endtask

  task automatic hold_sender(input bit quiet);
    int unsigned roll, len;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) len = 0;
    else if (roll < 93) len = $urandom_range(1, 5);
    else len = $urandom_range(30, 400);
    if (len != 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // wait until every item in flight has produced its result
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (ledger.due.size() != 0 || busy);
  endtask

  function automatic logic [CFG_W-1:0] pad_field(input logic [CFG_W-1:0] field,
                                                 input int w, input bit dirty);
    logic [CFG_W-1:0] keep;
    keep = (w >= CFG_W) ? '1 : ((CFG_W'(1) << w) - 1);
    return dirty ? ((field & keep) | ($urandom() & ~keep)) : field;
  endfunction

  // write every register, then the spare index, which must change nothing
  task automatic load_view(input view_t v, input bit dirty);
    logic [CFG_IDX_W-1:0] idx[8];
    logic [CFG_W-1:0]     val[8];
    idx[0] = CFG_MAX_ITER;  val[0] = pad_field(CFG_W'(v.bound), ITER_BITS, dirty);
    idx[1] = CFG_CENTER_X;  val[1] = pad_field(CFG_W'(v.cx), PIX_W, dirty);
    idx[2] = CFG_CENTER_Y;  val[2] = pad_field(CFG_W'(v.cy), PIX_W, dirty);
    idx[3] = CFG_SCALE_X;   val[3] = pad_field(CFG_W'(v.sx), SCALE_W, dirty);
    idx[4] = CFG_SCALE_Y;   val[4] = pad_field(CFG_W'(v.sy), SCALE_W, dirty);
    idx[5] = CFG_OFFSET_RE; val[5] = v.ore;
    idx[6] = CFG_OFFSET_IM; val[6] = v.oim;
    idx[7] = CFG_SPARE;     val[7] = $urandom();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      ledger.set_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    views_loaded++;
  endtask

  function automatic logic [PIX_W-1:0] near_pixel(input logic [PIX_W-1:0] cen,
                                                  input int unsigned reach);
    int p;
    p = int'(cen) + int'($urandom_range(0, 2 * reach)) - int'(reach);
    if (p < 0) p = 0;
    if (p > 4095) p = 4095;
    return p[PIX_W-1:0];
  endfunction

  initial begin
    view_t       v;
    int unsigned reach, base, run_len, remaining, roll, waited;
    bit          noisy, quiet;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: the origin never escapes, far corners saturate c
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    drain();

    // zero bound: no iteration at all
    v = ledger.regs;
    v.bound = '0;
    load_view(v, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // single iteration, pixels at or below centre, largest step, offsets at both ends
    v.bound = 12'd1;
    v.cx = 12'd4095;
    v.cy = 12'd4095;
    v.sx = '1;
    v.sy = '1;
    v.ore = 32'sh7fff_ffff;
    v.oim = 32'sh8000_0000;
    load_view(v, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    drain();

    // zero step pins c to the offset; full bound with c at zero
    v.bound = 12'd4095;
    v.cx = 12'd2048;
    v.cy = 12'd2048;
    v.sx = '0;
    v.sy = '0;
    v.ore = '0;
    v.oim = '0;
    load_view(v, 1'b0);
    send_pixel(12'd0, 12'd4095);
    drain();

    // c = -2 keeps |z|^2 exactly at 4, which must not count as escape
    v.ore = -32'sd536870912;
    load_view(v, 1'b0);
    send_pixel(12'd123, 12'd456);
    drain();

    // a window over the antenna of the ship
    v.bound = 12'd255;
    v.sx = 31'd786432;
    v.sy = 31'd786432;
    v.ore = -32'sd469762048;
    v.oim = -32'sd8053064;
    load_view(v, 1'b0);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd2000, 12'd2100);
    send_pixel(12'd2100, 12'd1990);
    send_pixel(12'd1500, 12'd2600);
    send_pixel(12'd2048, 12'd0);

    remaining = RANDOM_PIXELS;
    while (remaining > 0) begin
      drain();
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
        v.bound = ITER_BITS'($urandom_range(1, 48));
        run_len = $urandom_range(50, 90);
      end else if (roll < 95) begin
        v.bound = ITER_BITS'($urandom_range(49, 255));
        run_len = $urandom_range(15, 30);
      end else begin
        v.bound = ITER_BITS'($urandom_range(256, 1200));
        run_len = $urandom_range(3, 6);
      end
      noisy = ($urandom_range(0, 99) < 20);
      v.cx = PIX_W'($urandom_range(0, 4095));
      v.cy = PIX_W'($urandom_range(0, 4095));
      reach = 4 << (2 * $urandom_range(0, 4));
      if (noisy) begin
        v.sx = SCALE_W'($urandom());
        v.sy = SCALE_W'($urandom());
        v.ore = $urandom();
        v.oim = $urandom();
      end else begin
        base = WINDOW_SPAN / reach;
        v.sx = SCALE_W'($urandom_range(base / 2, base + base / 2));
        v.sy = SCALE_W'($urandom_range(base / 2, base + base / 2));
        v.ore = $urandom_range(0, WINDOW_SPAN) - 32'd536870912;
        v.oim = $urandom_range(0, WINDOW_SPAN) - 32'd536870912;
      end
      load_view(v, noisy);
      quiet = ($urandom_range(0, 3) == 0);
      if (run_len > remaining) run_len = remaining;
      repeat (run_len) begin
        if (noisy || $urandom_range(0, 99) < 15)
          send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
        else
          send_pixel(near_pixel(v.cx, reach), near_pixel(v.cy, reach));
        if ($urandom_range(0, 99) < 3) drain();
        hold_sender(quiet);
      end
      remaining -= run_len;
    end

    start <= 1'b0;
    waited = 0;
    while (ledger.due.size() != 0 && waited < 40000) begin
      @(posedge clk);
      waited++;
    end
    // catch any stray strobe after the last result
    repeat (64) @(posedge clk);
    if (ledger.due.size() != 0) begin
      ledger.faults++;
      $display("%0t: %0d items never produced a result", $time, ledger.due.size());
    end

    $display("%0d pixels over %0d register settings; %0d results checked, %0d hit the bound",
             pixels_sent, views_loaded, ledger.checked, ledger.held_count);
    $display("%0d mismatches", ledger.faults);
    if (ledger.faults == 0) begin
      $display("burning_ship_escape_time regression: pass");
    end else begin
      $display("burning_ship_escape_time regression: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("%0t: timed out with %0d items outstanding", $time, ledger.due.size());
    $display("burning_ship_escape_time regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bs_pkg.sv
hdl/bs_mul.sv
hdl/burning_ship_escape_time.sv
hdl/bs_chk.sv
test/burning_ship_escape_time_tb.sv
